@@ sv/amwb_pkg.sv @@
`timescale 1ns / 1ps

package amwb_pkg;

    localparam int PixW     = 32;
    localparam int ChanW    = 8;
    localparam int NumChan  = PixW / ChanW;
    localparam int MatteW   = 8;
    localparam int CfgW     = 16;
    localparam int CfgIdxW  = 2;
    localparam int DivSteps = 8;
    localparam int WShift   = 7;

    // register indexes on the configuration channel
    localparam logic [CfgIdxW-1:0] CFG_LENGTH   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_POSITION = 2'd1;

    localparam logic [CfgW-1:0]  LenReset    = 16'd1;
    localparam logic [CfgW-1:0]  PosReset    = 16'd0;
    localparam logic [ChanW-1:0] ChanMax     = 8'd255;
    localparam logic [ChanW-1:0] MatteOffset = 8'd86;

    // progress for the reset length and position, first and second field
    localparam logic [ChanW-1:0] P0Reset = 8'd0;
    localparam logic [ChanW-1:0] P1Reset = 8'd127;

    typedef logic [ChanW-1:0] chan_t;
    typedef logic [PixW-1:0]  pix_t;

    typedef struct packed {
        logic  busy;
        chan_t p0;
        chan_t p1;
    } prog_t;

    typedef struct packed {
        chan_t w;
        pix_t  a;
        pix_t  b;
    } wt_t;

endpackage

@@ sv/amwb_if.sv @@
`timescale 1ns / 1ps

interface amwb_in_if;
    import amwb_pkg::*;

    logic                valid;
    logic                ready;
    logic [PixW-1:0]     pixel_a;
    logic [PixW-1:0]     pixel_b;
    logic [MatteW-1:0]   matte_value;
    logic                second_field;

    modport source (output valid, pixel_a, pixel_b, matte_value, second_field,
                    input ready);
    modport sink (input valid, pixel_a, pixel_b, matte_value, second_field,
                  output ready);
endinterface

interface amwb_out_if;
    import amwb_pkg::*;

    logic            valid;
    logic            ready;
    logic [PixW-1:0] blended_pixel;

    modport source (output valid, blended_pixel, input ready);
    modport sink (input valid, blended_pixel, output ready);
endinterface

interface amwb_cfg_if;
    import amwb_pkg::*;

    logic               valid;
    logic               ready;
    logic [CfgIdxW-1:0] index;
    logic [CfgW-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/amwb_progress.sv @@
`timescale 1ns / 1ps

module amwb_progress (
    input  logic            clk,
    input  logic            rst_n,
    amwb_cfg_if.sink        cfg,
    output amwb_pkg::prog_t prog
);
    import amwb_pkg::*;

    localparam int DenW = CfgW + 1;
    localparam int NumW = DenW + ChanW;
    localparam int CntW = $clog2(DivSteps);

    logic [CfgW-1:0]  len_reg, len_next;
    logic [CfgW-1:0]  pos_reg, pos_next;
    logic             load_reg, load_next;
    logic             busy_reg, busy_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    chan_t            p0_reg, p0_next;
    chan_t            p1_reg, p1_next;

    logic [DenW-1:0]  rem0_reg, rem0_next;
    logic [DenW-1:0]  rem1_reg, rem1_next;
    chan_t            low0_reg, low0_next;
    chan_t            low1_reg, low1_next;
    chan_t            q0_reg, q0_next;
    chan_t            q1_reg, q1_next;
    logic             sat0_reg, sat0_next;
    logic             sat1_reg, sat1_next;

    logic             cfg_fire;
    logic             last_step;
    logic [DenW-1:0]  total;
    logic [DenW-1:0]  cur0;
    logic [DenW-1:0]  cur1;
    logic [NumW-1:0]  num0;
    logic [NumW-1:0]  num1;
    logic [DenW:0]    st0;
    logic [DenW:0]    st1;

    // one restoring step: shift in a dividend bit, subtract where it fits
    function automatic logic [DenW:0] div_step(input logic [DenW-1:0] rem,
                                               input logic nb,
                                               input logic [DenW-1:0] den);
        logic [DenW:0] sh;
        logic [DenW:0] diff;
        sh   = {rem, nb};
        diff = sh - {1'b0, den};
        if (sh >= {1'b0, den})
            div_step = {1'b1, diff[DenW-1:0]};
        else
            div_step = {1'b0, sh[DenW-1:0]};
    endfunction

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid & cfg.ready;

    assign total = {len_reg, 1'b0};
    assign cur0  = {pos_reg, 1'b0};
    assign cur1  = {pos_reg, 1'b1};
    assign num0  = {cur0, {ChanW{1'b0}}} - NumW'(cur0);
    assign num1  = {cur1, {ChanW{1'b0}}} - NumW'(cur1);
    assign st0   = div_step(rem0_reg, low0_reg[ChanW-1], total);
    assign st1   = div_step(rem1_reg, low1_reg[ChanW-1], total);

    assign last_step = busy_reg && !load_reg && (cnt_reg == CntW'(DivSteps - 1));

    always_comb
    begin
        len_next  = len_reg;
        pos_next  = pos_reg;
        if (cfg_fire)
        begin
            unique case (cfg.index)
                CFG_LENGTH:   len_next = cfg.data;
                CFG_POSITION: pos_next = cfg.data;
                default:      ;
            endcase
        end

        load_next = cfg_fire;
        busy_next = busy_reg;
        if (cfg_fire)
            busy_next = 1'b1;
        else if (last_step)
            busy_next = 1'b0;

        cnt_next = cnt_reg;
        if (load_reg)
            cnt_next = '0;
        else if (busy_reg)
            cnt_next = cnt_reg + CntW'(1);

        p0_next = p0_reg;
        p1_next = p1_reg;
        if (last_step)
        begin
            p0_next = sat0_reg ? ChanMax : {q0_reg[ChanW-2:0], st0[DenW]};
            p1_next = sat1_reg ? ChanMax : {q1_reg[ChanW-2:0], st1[DenW]};
        end
    end

    always_comb
    begin
        rem0_next = rem0_reg;
        rem1_next = rem1_reg;
        low0_next = low0_reg;
        low1_next = low1_reg;
        q0_next   = q0_reg;
        q1_next   = q1_reg;
        sat0_next = sat0_reg;
        sat1_next = sat1_reg;
        if (load_reg)
        begin
            // high part of cur*255 is below the divisor unless saturated
            rem0_next = num0[NumW-1:ChanW];
            rem1_next = num1[NumW-1:ChanW];
            low0_next = num0[ChanW-1:0];
            low1_next = num1[ChanW-1:0];
            q0_next   = '0;
            q1_next   = '0;
            sat0_next = (total == '0) || (cur0 >= total);
            sat1_next = (total == '0) || (cur1 >= total);
        end
        else if (busy_reg)
        begin
            rem0_next = st0[DenW-1:0];
            rem1_next = st1[DenW-1:0];
            low0_next = {low0_reg[ChanW-2:0], 1'b0};
            low1_next = {low1_reg[ChanW-2:0], 1'b0};
            q0_next   = {q0_reg[ChanW-2:0], st0[DenW]};
            q1_next   = {q1_reg[ChanW-2:0], st1[DenW]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LenReset;
            pos_reg  <= PosReset;
            load_reg <= 1'b0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            p0_reg   <= P0Reset;
            p1_reg   <= P1Reset;
        end
        else
        begin
            len_reg  <= len_next;
            pos_reg  <= pos_next;
            load_reg <= load_next;
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem0_reg <= rem0_next;
        rem1_reg <= rem1_next;
        low0_reg <= low0_next;
        low1_reg <= low1_next;
        q0_reg   <= q0_next;
        q1_reg   <= q1_next;
        sat0_reg <= sat0_next;
        sat1_reg <= sat1_next;
    end

    assign prog.busy = busy_reg;
    assign prog.p0   = p0_reg;
    assign prog.p1   = p1_reg;

    // the second field never lags the first
    a_field_order: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> p1_reg >= p0_reg)
        else $error("second field progress below first field");

    a_write_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> busy_reg && load_reg)
        else $error("register write did not restart progress divider");

    a_divide_ends: assert property (@(posedge clk) disable iff (!rst_n)
        last_step && !cfg_fire |=> !busy_reg)
        else $error("progress divider overran its step count");

endmodule

@@ sv/amwb_weight.sv @@
`timescale 1ns / 1ps

module amwb_weight (
    input  logic            clk,
    input  logic            rst_n,
    input  amwb_pkg::prog_t prog,
    amwb_in_if.sink         in_ch,
    output logic            w_vld,
    input  logic            w_rdy,
    output amwb_pkg::wt_t   wt
);
    import amwb_pkg::*;

    localparam int PrW = 2 * ChanW + 2;

    typedef struct packed {
        logic signed [PrW-1:0] m1;
        logic [PrW-2:0]        m2;
        pix_t                  a;
        pix_t                  b;
    } s1_t;

    logic vld1_reg, vld1_next;
    logic vld2_reg, vld2_next;
    s1_t  s1_reg, s1_next;
    wt_t  s2_reg, s2_next;
    logic rdy1;
    logic rdy2;
    logic fire_in;

    chan_t                   p;
    chan_t                   hp;
    logic [ChanW:0]          g;
    logic signed [ChanW+1:0] gg;
    logic signed [2*ChanW+3:0] m1_full;
    logic signed [PrW:0]     v;
    logic [PrW:0]            mag;
    logic [PrW:0]            sh;

    assign rdy2         = !vld2_reg || w_rdy;
    assign rdy1         = !vld1_reg || rdy2;
    assign in_ch.ready  = rdy1 && !prog.busy;
    assign fire_in      = in_ch.valid && in_ch.ready;

    // stage 1: the two weight products
    always_comb
    begin
        p       = in_ch.second_field ? prog.p1 : prog.p0;
        hp      = ChanMax - p;
        g       = {1'b0, in_ch.matte_value} + {1'b0, MatteOffset};
        gg      = $signed({2'b00, ChanMax}) - $signed({1'b0, g});
        m1_full = $signed({{(ChanW+4){1'b0}}, hp})
                * $signed({{(ChanW+2){gg[ChanW+1]}}, gg});
        s1_next    = s1_reg;
        vld1_next  = vld1_reg;
        if (rdy1)
        begin
            vld1_next = fire_in;
            if (fire_in)
            begin
                s1_next.m1 = m1_full[PrW-1:0];
                s1_next.m2 = (PrW-1)'(p) * (PrW-1)'(g);
                s1_next.a  = in_ch.pixel_a;
                s1_next.b  = in_ch.pixel_b;
            end
        end
    end

    // stage 2: difference, drop when above one code, magnitude, scale and clamp
    always_comb
    begin
        v   = $signed({s1_reg.m1[PrW-1], s1_reg.m1}) - $signed({2'b00, s1_reg.m2});
        if (v > $signed((PrW+1)'(ChanMax)))
            mag = '0;
        else if (v < 0)
            mag = (PrW+1)'(-v);
        else
            mag = (PrW+1)'(v);
        sh  = mag >> WShift;
        s2_next   = s2_reg;
        vld2_next = vld2_reg;
        if (rdy2)
        begin
            vld2_next = vld1_reg;
            if (vld1_reg)
            begin
                s2_next.w = (sh > (PrW+1)'(ChanMax)) ? ChanMax : sh[ChanW-1:0];
                s2_next.a = s1_reg.a;
                s2_next.b = s1_reg.b;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld1_next;
            vld2_reg <= vld2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    assign w_vld = vld2_reg;
    assign wt    = s2_reg;

endmodule

@@ sv/amwb_mix.sv @@
`timescale 1ns / 1ps

module amwb_mix (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          w_vld,
    output logic          w_rdy,
    input  amwb_pkg::wt_t wt,
    amwb_out_if.source    out_ch
);
    import amwb_pkg::*;

    localparam int PrW = 2 * ChanW + 2;
    localparam int MgW = 2 * ChanW;

    typedef struct packed {
        logic [NumChan-1:0][PrW-1:0] prod;
        pix_t                        a;
    } s3_t;

    logic vld3_reg, vld3_next;
    logic vld4_reg, vld4_next;
    s3_t  s3_reg, s3_next;
    pix_t out_reg, out_next;
    logic rdy3;
    logic rdy4;

    assign rdy4  = !vld4_reg || out_ch.ready;
    assign rdy3  = !vld3_reg || rdy4;
    assign w_rdy = rdy3;

    // stage 3: weight times signed channel difference, one lane per channel
    always_comb
    begin
        logic signed [ChanW:0]  d;
        logic signed [PrW-1:0]  pr;
        d         = '0;
        pr        = '0;
        s3_next   = s3_reg;
        vld3_next = vld3_reg;
        if (rdy3)
        begin
            vld3_next = w_vld;
            if (w_vld)
            begin
                for (int k = 0; k < NumChan; k++)
                begin
                    d  = $signed({1'b0, wt.a[k*ChanW +: ChanW]})
                       - $signed({1'b0, wt.b[k*ChanW +: ChanW]});
                    pr = PrW'($signed({1'b0, wt.w})) * PrW'(d);
                    s3_next.prod[k] = pr;
                end
                s3_next.a = wt.a;
            end
        end
    end

    // stage 4: divide by 255 toward zero through the reciprocal, apply to a
    always_comb
    begin
        logic            neg;
        logic [PrW-1:0]  pmag;
        logic [MgW:0]    qs;
        chan_t           q;
        chan_t           ak;
        neg       = 1'b0;
        pmag      = '0;
        qs        = '0;
        q         = '0;
        ak        = '0;
        out_next  = out_reg;
        vld4_next = vld4_reg;
        if (rdy4)
        begin
            vld4_next = vld3_reg;
            if (vld3_reg)
            begin
                for (int k = 0; k < NumChan; k++)
                begin
                    neg  = s3_reg.prod[k][PrW-1];
                    pmag = neg ? (PrW)'(-$signed(s3_reg.prod[k])) : s3_reg.prod[k];
                    qs   = ({1'b0, pmag[MgW-1:0]} + (MgW+1)'(pmag[MgW-1:ChanW])
                           + (MgW+1)'(1)) >> ChanW;
                    q    = qs[ChanW-1:0];
                    ak   = s3_reg.a[k*ChanW +: ChanW];
                    out_next[k*ChanW +: ChanW] = neg ? ak + q : ak - q;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else
        begin
            vld3_reg <= vld3_next;
            vld4_reg <= vld4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_reg  <= s3_next;
        out_reg <= out_next;
    end

    assign out_ch.valid         = vld4_reg;
    assign out_ch.blended_pixel = out_reg;

endmodule

@@ sv/alpha_matte_wipe_blend.sv @@
`timescale 1ns / 1ps

// Matte-driven wipe between two packed four-channel pixel words. One word is
// accepted per clock while the divider is idle and the output is not stalled;
// its blended result passes through a four-stage pipeline (weight products,
// weight clamp, channel products, divide by 255 into the output register); each
// stage holds its own valid bit, so a stalled output fills the bubbles before
// input is held off. Any register write restarts an eight-step shift-subtract
// divider that turns length and position into the progress of both fields;
// input is held off while it runs. After reset the progress values are ready
// at once.
module alpha_matte_wipe_blend (
    input  logic       clk,
    input  logic       rst_n,
    amwb_in_if.sink    in_ch,
    amwb_out_if.source out_ch,
    amwb_cfg_if.sink   cfg
);
    import amwb_pkg::*;

    prog_t prog;
    wt_t   wt;
    logic  w_vld;
    logic  w_rdy;

    amwb_progress u_progress (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .prog  (prog)
    );

    amwb_weight u_weight (
        .clk   (clk),
        .rst_n (rst_n),
        .prog  (prog),
        .in_ch (in_ch),
        .w_vld (w_vld),
        .w_rdy (w_rdy),
        .wt    (wt)
    );

    amwb_mix u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .w_vld  (w_vld),
        .w_rdy  (w_rdy),
        .wt     (wt),
        .out_ch (out_ch)
    );

endmodule

@@ bench/tb_alpha_matte_wipe_blend.sv @@
`timescale 1ns / 1ps

module tb_alpha_matte_wipe_blend;
    import amwb_pkg::*;

    typedef struct packed {
        logic [CfgW-1:0] len;
        logic [CfgW-1:0] pos;
        pix_t            a;
        pix_t            b;
        chan_t           matte;
        logic            fld;
        logic            fixed;
        pix_t            want;
    } wipe_case_t;

    localparam int NumCases  = 21;
    localparam int NumPhases = 12;
    localparam int PhaseLen  = 50;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    amwb_in_if  in_bus ();
    amwb_out_if out_bus ();
    amwb_cfg_if cfg_bus ();

    alpha_matte_wipe_blend dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus),
        .cfg    (cfg_bus)
    );

    always #5 clk = ~clk;

    pix_t            blended_due [$];
    pix_t            oldest_due;
    logic [CfgW-1:0] len_reg;
    logic [CfgW-1:0] pos_reg;
    int              errors          = 0;
    int              items_sent      = 0;
    int              results_checked = 0;
    int              settings_used   = 0;
    int              stall_pct       = 20;
    int              gap_pct         = 20;

    // length, position, a, b, matte, field, fixed, expected word if fixed
    wipe_case_t wipe_cases [NumCases] = '{
        '{16'd1, 16'd0, 32'h12345678, 32'hFEDCBA98, 8'd0, 1'b0, 1'b1, 32'h12345678},
        '{16'd1, 16'd0, 32'hFFFFFFFF, 32'h00000000, 8'd169, 1'b0, 1'b1, 32'hFFFFFFFF},
        '{16'd1, 16'd0, 32'h00000000, 32'hFFFFFFFF, 8'd255, 1'b0, 1'b0, 32'h0},
        '{16'd1, 16'd0, 32'hA5A5A5A5, 32'h5A5A5A5A, 8'd128, 1'b1, 1'b0, 32'h0},
        '{16'd1, 16'd0, 32'hFFFFFFFF, 32'h00000000, 8'd255, 1'b1, 1'b0, 32'h0},
        // zero length counts as a finished transition
        '{16'd0, 16'd0, 32'hFFFFFFFF, 32'h00000000, 8'd255, 1'b0, 1'b1, 32'h00000000},
        '{16'd0, 16'd0, 32'h00000000, 32'hFFFFFFFF, 8'd255, 1'b1, 1'b1, 32'hFFFFFFFF},
        '{16'd0, 16'd0, 32'h80808080, 32'h7F7F7F7F, 8'd0, 1'b0, 1'b0, 32'h0},
        // position at or beyond length saturates progress; then rows at the longest length
        '{16'd1, 16'd5, 32'h0F0F0F0F, 32'hF0F0F0F0, 8'd255, 1'b0, 1'b1, 32'hF0F0F0F0},
        '{16'd3, 16'hFFFF, 32'h01234567, 32'h89ABCDEF, 8'd255, 1'b1, 1'b1, 32'h89ABCDEF},
        '{16'd3, 16'hFFFF, 32'h01234567, 32'h89ABCDEF, 8'd0, 1'b0, 1'b0, 32'h0},
        '{16'hFFFF, 16'd0, 32'hFFFFFFFF, 32'h00000000, 8'd100, 1'b0, 1'b1, 32'hFFFFFFFF},
        '{16'hFFFF, 16'd0, 32'hFFFFFFFF, 32'h00000000, 8'd255, 1'b1, 1'b0, 32'h0},
        '{16'hFFFF, 16'hFFFF, 32'h00FF00FF, 32'hFF00FF00, 8'd255, 1'b0, 1'b1, 32'hFF00FF00},
        '{16'hFFFF, 16'd32767, 32'h11111111, 32'hEEEEEEEE, 8'd42, 1'b1, 1'b0, 32'h0},
        // weight just either side of the cut-off
        '{16'd2, 16'd1, 32'h0F0F0F0F, 32'hF0F0F0F0, 8'd41, 1'b0, 1'b0, 32'h0},
        '{16'd2, 16'd1, 32'h0F0F0F0F, 32'hF0F0F0F0, 8'd42, 1'b0, 1'b0, 32'h0},
        '{16'd2, 16'd1, 32'hC3C3C3C3, 32'h3C3C3C3C, 8'd200, 1'b1, 1'b0, 32'h0},
        '{16'd4, 16'd3, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255, 1'b1, 1'b1, 32'hFFFFFFFF},
        '{16'd4, 16'd3, 32'h00000000, 32'h00000000, 8'd0, 1'b0, 1'b1, 32'h00000000},
        '{16'd1, 16'd0, 32'h7F807F80, 32'h807F807F, 8'd255, 1'b0, 1'b0, 32'h0}
    };

    function automatic int progress_of(logic [CfgW-1:0] len, logic [CfgW-1:0] pos,
                                       logic fld);
        int total;
        int cur;
        int p;
        total = int'(len);
        total = total * 2;
        cur   = int'(pos);
        cur   = cur * 2 + int'(fld);
        if (total == 0)
            return 255;
        p = (cur * 255) / total;
        return (p > 255) ? 255 : p;
    endfunction

    function automatic int weight_of(chan_t matte, int p);
        int g;
        int v;
        int w;
        g = int'(matte);
        g = g + 86;
        v = (255 - p) * (255 - g) - p * g;
        if (v > 255)
            v = 0;
        if (v < 0)
            v = -v;
        w = v >> 7;
        return (w > 255) ? 255 : w;
    endfunction

    function automatic pix_t wipe_blend_of(pix_t a, pix_t b, chan_t matte, logic fld,
                                           logic [CfgW-1:0] len, logic [CfgW-1:0] pos);
        int   w;
        int   sa;
        int   sb;
        int   r;
        pix_t res;
        w = weight_of(matte, progress_of(len, pos, fld));
        for (int k = 0; k < NumChan; k++)
        begin
            sa = int'(a[k*ChanW +: ChanW]);
            sb = int'(b[k*ChanW +: ChanW]);
            // signed division truncates toward zero
            r  = sa - (w * (sa - sb)) / 255;
            res[k*ChanW +: ChanW] = r[ChanW-1:0];
        end
        return res;
    endfunction

    task automatic push_pixel(input pix_t a, input pix_t b, input chan_t matte,
                              input logic fld, input pix_t want);
        in_bus.valid        <= 1'b1;
        in_bus.pixel_a      <= a;
        in_bus.pixel_b      <= b;
        in_bus.matte_value  <= matte;
        in_bus.second_field <= fld;
        do
            @(posedge clk);
        while (!in_bus.ready);
        blended_due.push_back(want);
        items_sent++;
    endtask

    // hold the input until every outstanding transaction has come out
    task automatic settle_outputs();
        in_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (blended_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
    endtask

    task automatic set_transition(input logic [CfgW-1:0] len, input logic [CfgW-1:0] pos);
        settle_outputs();
        write_reg(CFG_LENGTH, len);
        len_reg = len;
        write_reg(CFG_POSITION, pos);
        pos_reg = pos;
        cfg_bus.valid <= 1'b0;
        settings_used++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (blended_due.size() == 0)
            begin
                errors++;
                $display("%0t: result with none outstanding, expected nothing, got %08h",
                         $time, out_bus.blended_pixel);
            end
            else
            begin
                oldest_due = blended_due.pop_front();
                results_checked++;
                if (out_bus.blended_pixel !== oldest_due)
                begin
                    errors++;
                    $display("%0t: blended_pixel mismatch, expected %08h, got %08h",
                             $time, oldest_due, out_bus.blended_pixel);
                end
            end
        end
    end

    // output back-pressure in short bursts
    initial
    begin
        out_bus.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
            begin
                out_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial
    begin : stimulus
        wipe_case_t      row;
        pix_t            a;
        pix_t            b;
        pix_t            want;
        chan_t           matte;
        logic            fld;
        logic [CfgW-1:0] nl;
        logic [CfgW-1:0] np;

        in_bus.valid        = 1'b0;
        in_bus.pixel_a      = '0;
        in_bus.pixel_b      = '0;
        in_bus.matte_value  = '0;
        in_bus.second_field = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = CFG_LENGTH;
        cfg_bus.data        = '0;
        len_reg             = LenReset;
        pos_reg             = PosReset;

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NumCases; i++)
        begin
            row = wipe_cases[i];
            if (row.len != len_reg || row.pos != pos_reg)
                set_transition(row.len, row.pos);
            want = row.fixed ? row.want
                             : wipe_blend_of(row.a, row.b, row.matte, row.fld, len_reg, pos_reg);
            push_pixel(row.a, row.b, row.matte, row.fld, want);
        end

        for (int ph = 0; ph < NumPhases; ph++)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    nl = CfgW'($urandom_range(1, 8));
                    np = CfgW'($urandom_range(0, nl));
                end
                1:
                begin
                    nl = CfgW'($urandom_range(1, 300));
                    np = CfgW'($urandom_range(0, nl + 1));
                end
                2:
                begin
                    nl = CfgW'($urandom);
                    np = CfgW'($urandom);
                end
                3:
                begin
                    nl = '0;
                    np = CfgW'($urandom);
                end
                4:
                begin
                    nl = '1;
                    np = CfgW'($urandom);
                end
                default:
                begin
                    nl = CfgW'($urandom_range(1, 20));
                    np = CfgW'(nl + $urandom_range(0, 1000));
                end
            endcase
            set_transition(nl, np);

            if (ph == NumPhases - 1)
            begin
                stall_pct = 0;
                gap_pct   = 0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    2:       stall_pct = 30;
                    default: stall_pct = 60;
                endcase
                gap_pct = $urandom_range(0, 3) * 15;
            end

            for (int k = 0; k < PhaseLen; k++)
            begin
                if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
                begin
                    in_bus.valid <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge clk);
                end
                else if (ph != NumPhases - 1 && $urandom_range(0, 99) == 0)
                    settle_outputs();
                a     = $urandom;
                b     = ($urandom_range(0, 7) == 0) ? a : pix_t'($urandom);
                matte = chan_t'($urandom_range(0, 255));
                fld   = 1'($urandom_range(0, 1));
                push_pixel(a, b, matte, fld,
                           wipe_blend_of(a, b, matte, fld, len_reg, pos_reg));
            end
        end

        in_bus.valid <= 1'b0;
        for (int t = 0; t < 1000 && blended_due.size() != 0; t++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (blended_due.size() != 0)
        begin
            errors += blended_due.size();
            $display("%0t: %0d results never arrived, expected none left, got %0d",
                     $time, blended_due.size(), blended_due.size());
        end

        $display("Run covered %0d pixel words and %0d blended results checked,",
                 items_sent, results_checked);
        $display("over %0d length/position settings with random stalls on both sides.",
                 settings_used);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/amwb_pkg.sv
sv/amwb_if.sv
sv/amwb_progress.sv
sv/amwb_weight.sv
sv/amwb_mix.sv
sv/alpha_matte_wipe_blend.sv
bench/tb_alpha_matte_wipe_blend.sv
